// ===== hdl/animation_timeline_sequencer_top_macros.svh =====
// Assertion shorthands for the timeline sequencer, all clocked on clk and
// held off while rst is high.
`ifndef ANIMATION_TIMELINE_SEQUENCER_TOP_MACROS_SVH
`define ANIMATION_TIMELINE_SEQUENCER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ats_pkg.sv =====
package ats_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int PHASE_FRAC_DEF = 16;

  localparam int NOW_W  = 32;
  localparam int OPC_W  = 3;
  localparam int DUR_W  = 16;
  localparam int RC_W   = 17;
  localparam int RUNS_W = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_DURATION  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REPEAT    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_REVERSE   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FILL_BEF  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FILL_AFT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FILL_EN   = 3'd6;

  typedef enum logic [OPC_W-1:0] {
    OP_FRAME      = 3'd0,
    OP_START_NEXT = 3'd1,
    OP_START_AT   = 3'd2,
    OP_CANCEL     = 3'd3,
    OP_PAUSE      = 3'd4,
    OP_RESUME     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIFF,
    ST_MAGN,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/animation_timeline_sequencer_top.sv =====
// Animation timeline sequencer.
// Input stream: one word per timeline event. s_tuser carries the opcode
// (frame, start on next frame, start at time, cancel, pause, resume) and
// s_tdata the 32-bit millisecond timestamp. Every input word yields exactly
// one output word on the m_ side with the applied flag, the Q2.16 phase,
// the more flag, the start/repeat/end events and the started/ended marks.
// Timing is programmed through the cfg_we/cfg_addr/cfg_wdata write port; the user
// must write it only while the block is idle, which the block does not enforce.
// Path: a frame whose phase needs the divider passes the time arithmetic
// states EXEC, DIFF and MAGN, then a restoring divider that retires one
// quotient bit per cycle over PHASE_FRAC_BITS+18 steps (34 at default),
// then the FIN state. Frames outside four durations and zero-duration
// frames skip the divider; canceled frames and other events go from EXEC
// straight to FIN. The sequencer returns to idle after each word and takes
// a new word only there, so it never takes one before the last is through.
// s_tready is high whenever the sequencer is idle, also while a finished
// word still waits in the output register. If the receiver stalls, the
// next word finishes its work and holds until the output register frees.
// Reset (synchronous, active high) restores register defaults, sets the
// start-pending mark and clears all other marks and the output valid.
`include "animation_timeline_sequencer_top_macros.svh"

module animation_timeline_sequencer_top #(
  parameter int TIME_BITS       = ats_pkg::TIME_BITS_DEF,
  parameter int PHASE_FRAC_BITS = ats_pkg::PHASE_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ats_pkg::NOW_W-1:0]         s_tdata,   // [31:0] now_ms
  input  logic [ats_pkg::OPC_W-1:0]         s_tuser,   // [2:0] opcode
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] applied, [F+2:1] phase, [F+3] more, [F+4] start_event,
  // [F+5] repeat_event, [F+6] end_event, [F+7] is_started,
  // [F+8] is_ended, rest zero (F = PHASE_FRAC_BITS)
  output logic [((PHASE_FRAC_BITS+9+7)/8)*8-1:0] m_tdata,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ats_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [ats_pkg::CFG_DW-1:0]        cfg_wdata
);

  localparam int F         = PHASE_FRAC_BITS;
  localparam int PW        = F + 2;
  localparam int OUT_W     = ((F + 9 + 7) / 8) * 8;
  localparam int DUR_W     = ats_pkg::DUR_W;
  localparam int MAG_W     = DUR_W + 2;
  localparam int CW        = (TIME_BITS > MAG_W) ? TIME_BITS : MAG_W;
  localparam int DIV_STEPS = MAG_W + F;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic signed [PW-1:0] PH_ONE = {2'b01, {F{1'b0}}};
  localparam logic signed [PW-1:0] PH_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PH_MIN = {1'b1, {(PW-1){1'b0}}};

  // saturate one extra bit of range down to the phase width
  function automatic logic signed [PW-1:0] sat_ph(input logic signed [PW:0] v);
    if (v[PW] != v[PW-1]) begin
      return v[PW] ? PH_MIN : PH_MAX;
    end
    return v[PW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] clamp01(input logic signed [PW-1:0] v);
    if (v[PW-1]) begin
      return '0;
    end
    if (v > PH_ONE) begin
      return PH_ONE;
    end
    return v;
  endfunction

  // configuration registers
  logic [DUR_W-1:0]        duration_ms;
  logic [DUR_W-1:0]        start_offset_ms;
  logic [ats_pkg::RC_W-1:0] repeat_count;
  logic                    reverse_mode;
  logic                    fill_before;
  logic                    fill_after;
  logic                    fill_enabled;

  // timeline state
  ats_pkg::state_t          state, state_next;
  logic [TIME_BITS-1:0]     start_time, start_time_next;
  logic [TIME_BITS-1:0]     pause_time, pause_time_next;
  logic                     start_pending, start_pending_next;
  logic                     canceled_mark, canceled_mark_next;
  logic                     started_mark, started_mark_next;
  logic                     ended_mark, ended_mark_next;
  logic                     paused_mark, paused_mark_next;
  logic [ats_pkg::RUNS_W-1:0] runs_done, runs_done_next;
  logic                     direction_flip, direction_flip_next;

  // working registers of the current word
  ats_pkg::op_t             op_r;
  logic [TIME_BITS-1:0]     now_r;
  logic [TIME_BITS-1:0]     tmp;
  logic                     neg_r, big_r, after_r, expd_r;

  // divider
  logic [DIV_STEPS-1:0]     div_n;
  logic [DUR_W-1:0]         rem;
  logic [PW-1:0]            quot;
  logic [CNT_W-1:0]         cnt;
  logic [DUR_W:0]           trial;
  logic                     ge;

  // control
  logic                     out_free;
  logic                     fin_fire;
  logic                     div_en;

  // magnitude stage
  logic                     neg_c;
  logic [TIME_BITS-1:0]     mag;
  logic [CW-1:0]            mag_c;
  logic                     after_c, expd_c, big_c;

  // result of the current word
  logic                     res_applied, res_more, res_start, res_repeat, res_end;
  logic signed [PW-1:0]     res_phase;

  logic [TIME_BITS-1:0]     now_ext;
  logic                     dur_zero;
  logic                     rc_eq, rc_pos;

  generate
    if (TIME_BITS > ats_pkg::NOW_W) begin : g_now_wide
      assign now_ext = {{(TIME_BITS-ats_pkg::NOW_W){1'b0}}, s_tdata};
    end else begin : g_now_narrow
      assign now_ext = s_tdata[TIME_BITS-1:0];
    end
  endgenerate

  assign dur_zero = (duration_ms == '0);
  assign rc_eq    = !repeat_count[ats_pkg::RC_W-1] &&
                    (repeat_count[ats_pkg::RUNS_W-1:0] == runs_done);
  assign rc_pos   = !repeat_count[ats_pkg::RC_W-1] && (repeat_count != '0);

  // magnitude of the signed time difference held in tmp, with the exact
  // before/after/expiry compares against the duration
  always_comb begin
    neg_c   = tmp[TIME_BITS-1];
    mag     = neg_c ? ('0 - tmp) : tmp;
    mag_c   = CW'(mag);
    after_c = !neg_c && (mag_c > CW'(duration_ms));
    expd_c  = !neg_c && (mag_c >= CW'(duration_ms));
    big_c   = mag_c >= CW'({duration_ms, 2'b00});
  end

  // one restoring division step
  always_comb begin
    trial = {rem, div_n[DIV_STEPS-1]};
    ge    = trial >= {1'b0, duration_ms};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ats_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ats_pkg::ST_EXEC;
        end
      end
      ats_pkg::ST_EXEC: begin
        if (op_r == ats_pkg::OP_FRAME && !canceled_mark) begin
          state_next = ats_pkg::ST_DIFF;
        end else begin
          state_next = ats_pkg::ST_FIN;
        end
      end
      ats_pkg::ST_DIFF: state_next = ats_pkg::ST_MAGN;
      ats_pkg::ST_MAGN: begin
        if (!dur_zero && !big_c) begin
          state_next = ats_pkg::ST_DIV;
        end else begin
          state_next = ats_pkg::ST_FIN;
        end
      end
      ats_pkg::ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ats_pkg::ST_FIN;
        end
      end
      ats_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = ats_pkg::ST_IDLE;
        end
      end
      default: state_next = ats_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free = !m_tvalid || m_tready;
    s_tready = (state == ats_pkg::ST_IDLE) && !rst;
    div_en   = (state == ats_pkg::ST_DIV);
    fin_fire = (state == ats_pkg::ST_FIN) && out_free;
  end

  // finish: fold the raw phase through the fill, clamp and flip rules and
  // work out the mark updates
  always_comb begin : fin_logic
    logic signed [PW-1:0] ph0, ph1, ph2, ph3;
    logic signed [PW:0]   qs;
    logic                 bef, aft, expd, apply, stop;

    qs  = {1'b0, quot};
    bef = 1'b0;
    aft = 1'b0;
    if (canceled_mark) begin
      ph0  = PH_MAX;
      aft  = 1'b1;
      expd = 1'b1;
    end else if (!dur_zero) begin
      if (big_r) begin
        ph0 = neg_r ? PH_MIN : PH_MAX;
      end else begin
        ph0 = sat_ph(neg_r ? -qs : qs);
      end
      bef  = neg_r;
      aft  = after_r;
      expd = expd_r;
    end else begin
      // zero duration: step at the start time
      ph0  = neg_r ? '0 : PH_ONE;
      expd = !neg_r;
    end

    ph1 = ph0;
    if (!fill_enabled || repeat_count != '0) begin
      ph1 = clamp01(ph0);
      bef = 1'b0;
      aft = 1'b0;
    end
    apply = (!bef || fill_before) && (!aft || fill_after);
    ph2   = fill_enabled ? clamp01(ph1) : ph1;
    ph3   = direction_flip ?
            sat_ph({PH_ONE[PW-1], PH_ONE} - {ph2[PW-1], ph2}) : ph2;
    stop  = rc_eq || canceled_mark;

    res_applied         = 1'b0;
    res_phase           = '0;
    res_more            = 1'b0;
    res_start           = 1'b0;
    res_repeat          = 1'b0;
    res_end             = 1'b0;
    start_time_next     = start_time;
    pause_time_next     = pause_time;
    start_pending_next  = start_pending;
    canceled_mark_next  = canceled_mark;
    started_mark_next   = started_mark;
    ended_mark_next     = ended_mark;
    paused_mark_next    = paused_mark;
    runs_done_next      = runs_done;
    direction_flip_next = direction_flip;

    unique case (op_r)
      ats_pkg::OP_FRAME: begin
        res_more = !expd;
        if (apply) begin
          res_applied = 1'b1;
          res_phase   = ph3;
          if (!started_mark) begin
            started_mark_next = 1'b1;
            res_start         = 1'b1;
          end
        end
        if (expd) begin
          if (stop) begin
            if (!ended_mark) begin
              ended_mark_next = 1'b1;
              res_end         = 1'b1;
            end
          end else begin
            runs_done_next = rc_pos ? runs_done + 1'b1 : ats_pkg::RUNS_W'(1);
            if (reverse_mode) begin
              direction_flip_next = !direction_flip;
            end
            start_time_next = now_r;
            res_more        = 1'b1;
            res_repeat      = 1'b1;
          end
        end
      end
      ats_pkg::OP_START_NEXT, ats_pkg::OP_START_AT: begin
        if (op_r == ats_pkg::OP_START_AT) begin
          start_time_next    = now_r;
          start_pending_next = 1'b0;
        end else begin
          start_pending_next = 1'b1;
        end
        canceled_mark_next  = 1'b0;
        started_mark_next   = 1'b0;
        ended_mark_next     = 1'b0;
        direction_flip_next = 1'b0;
        runs_done_next      = '0;
      end
      ats_pkg::OP_CANCEL: begin
        if (started_mark && !ended_mark) begin
          canceled_mark_next = 1'b1;
          ended_mark_next    = 1'b1;
          res_end            = 1'b1;
        end
      end
      ats_pkg::OP_PAUSE: begin
        if (!ended_mark && !paused_mark) begin
          paused_mark_next = 1'b1;
          pause_time_next  = now_r;
        end
      end
      ats_pkg::OP_RESUME: begin
        if (!ended_mark && paused_mark) begin
          paused_mark_next = 1'b0;
          if (!start_pending) begin
            // tmp holds the paused span
            start_time_next = start_time + tmp;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms     <= '0;
      start_offset_ms <= '0;
      repeat_count    <= '0;
      reverse_mode    <= 1'b0;
      fill_before     <= 1'b0;
      fill_after      <= 1'b1;
      fill_enabled    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ats_pkg::REG_DURATION: duration_ms     <= cfg_wdata[DUR_W-1:0];
        ats_pkg::REG_OFFSET:   start_offset_ms <= cfg_wdata[DUR_W-1:0];
        ats_pkg::REG_REPEAT:   repeat_count    <= cfg_wdata;
        ats_pkg::REG_REVERSE:  reverse_mode    <= cfg_wdata[0];
        ats_pkg::REG_FILL_BEF: fill_before     <= cfg_wdata[0];
        ats_pkg::REG_FILL_AFT: fill_after      <= cfg_wdata[0];
        ats_pkg::REG_FILL_EN:  fill_enabled    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer, timeline state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ats_pkg::ST_IDLE;
      start_time     <= '0;
      pause_time     <= '0;
      start_pending  <= 1'b1;
      canceled_mark  <= 1'b0;
      started_mark   <= 1'b0;
      ended_mark     <= 1'b0;
      paused_mark    <= 1'b0;
      runs_done      <= '0;
      direction_flip <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;

      if (s_tvalid && s_tready) begin
        op_r  <= ats_pkg::op_t'(s_tuser);
        now_r <= now_ext;
      end

      if (state == ats_pkg::ST_EXEC) begin
        if (op_r == ats_pkg::OP_FRAME) begin
          // latch the start on the first frame, then form the run base
          if (start_pending) begin
            start_time    <= now_r;
            start_pending <= 1'b0;
            tmp <= now_r + ((!dur_zero && runs_done == '0) ?
                            TIME_BITS'(start_offset_ms) : '0);
          end else begin
            tmp <= start_time + ((!dur_zero && runs_done == '0) ?
                                 TIME_BITS'(start_offset_ms) : '0);
          end
        end else begin
          tmp <= now_r - pause_time;
        end
      end

      if (state == ats_pkg::ST_DIFF) begin
        tmp <= now_r - tmp;
      end

      if (state == ats_pkg::ST_MAGN) begin
        neg_r   <= neg_c;
        big_r   <= big_c;
        after_r <= after_c;
        expd_r  <= expd_c;
        div_n   <= {mag_c[MAG_W-1:0], {F{1'b0}}};
        rem     <= '0;
        cnt     <= CNT_W'(DIV_STEPS);
      end

      // one quotient bit per cycle
      if (div_en) begin
        rem   <= ge ? DUR_W'(trial - {1'b0, duration_ms}) : trial[DUR_W-1:0];
        div_n <= div_n << 1;
        quot  <= {quot[PW-2:0], ge};
        cnt   <= cnt - 1'b1;
      end

      if (fin_fire) begin
        start_time     <= start_time_next;
        pause_time     <= pause_time_next;
        start_pending  <= start_pending_next;
        canceled_mark  <= canceled_mark_next;
        started_mark   <= started_mark_next;
        ended_mark     <= ended_mark_next;
        paused_mark    <= paused_mark_next;
        runs_done      <= runs_done_next;
        direction_flip <= direction_flip_next;
        m_tvalid       <= 1'b1;
        m_tdata        <= OUT_W'({ended_mark_next, started_mark_next, res_end,
                                  res_repeat, res_start, res_more, res_phase,
                                  res_applied});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // the partial remainder stays below the divisor through every step
  `ATS_ASSERT_NOW(a_div_rem_bound, state == ats_pkg::ST_DIV, rem < duration_ms, "divider remainder out of range")

  // a word without an applied frame carries a zero phase
  `ATS_ASSERT_NOW(a_phase_zero, m_tvalid && !m_tdata[0], m_tdata[PW:1] == '0, "phase set on a word with no frame applied")

  // only a start event clears the ended mark
  `ATS_ASSERT_NEXT(a_ended_sticky, ended_mark && !(fin_fire && (op_r == ats_pkg::OP_START_NEXT || op_r == ats_pkg::OP_START_AT)), ended_mark, "ended mark dropped without a start")

  // an end event always leaves the ended mark set
  `ATS_ASSERT_NEXT(a_end_sets_mark, fin_fire && res_end, ended_mark && m_tvalid, "end event without ended mark")

endmodule

// ===== dv/tb_animation_timeline_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_animation_timeline_sequencer_top;
  import ats_pkg::*;

  localparam int FRAC  = PHASE_FRAC_DEF;
  localparam int OUT_W = ((FRAC + 9 + 7) / 8) * 8;

  // Q2.16 phase landmarks
  localparam longint PH_ONE = longint'(1) << FRAC;
  localparam longint PH_MAX = (longint'(1) << (FRAC + 1)) - 1;
  localparam longint PH_MIN = -(longint'(1) << (FRAC + 1));

  // opcodes the block must ignore
  localparam logic [OPC_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL    = 200;   // last words sent with no idling on either side
  localparam int DRAIN_SETTLE = 48;    // covers the divider path with margin
  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int MAX_REPORTS  = 10;

  // Output word, most significant field first so that applied lands on bit 0.
  typedef struct packed {
    logic [OUT_W-FRAC-10:0] pad;
    logic                   is_ended;
    logic                   is_started;
    logic                   end_event;
    logic                   repeat_event;
    logic                   start_event;
    logic                   more;
    logic [FRAC+1:0]        phase;
    logic                   applied;
  } seq_word_t;

  // Tracks the timeline state, predicts one output word per input word and
  // checks the words leaving the block in order.
  class timeline_scoreboard;
    bit [15:0]        dur_ms;
    bit [15:0]        offset_ms;
    bit signed [16:0] rep_count;
    bit               rev_mode;
    bit               fill_bef;
    bit               fill_aft;
    bit               fill_on;

    bit [31:0] start_ms;
    bit [31:0] pause_ms;
    bit        start_pending;
    bit        canceled;
    bit        started;
    bit        ended;
    bit        paused;
    bit        flipped;
    bit [15:0] runs;

    seq_word_t expected_words[$];
    int        mismatches;
    int        words_checked;

    function new();
      dur_ms = '0; offset_ms = '0; rep_count = '0;
      rev_mode = 1'b0; fill_bef = 1'b0; fill_aft = 1'b1; fill_on = 1'b1;
      start_ms = '0; pause_ms = '0;
      start_pending = 1'b1;
      canceled = 1'b0; started = 1'b0; ended = 1'b0; paused = 1'b0;
      flipped = 1'b0; runs = '0;
      mismatches = 0; words_checked = 0;
    endfunction

    function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_DURATION: dur_ms    = val[15:0];
        REG_OFFSET:   offset_ms = val[15:0];
        REG_REPEAT:   rep_count = val;
        REG_REVERSE:  rev_mode  = val[0];
        REG_FILL_BEF: fill_bef  = val[0];
        REG_FILL_AFT: fill_aft  = val[0];
        REG_FILL_EN:  fill_on   = val[0];
        default: ;
      endcase
    endfunction

    function longint clip_phase(longint p);
      if (p > PH_MAX) return PH_MAX;
      if (p < PH_MIN) return PH_MIN;
      return p;
    endfunction

    function longint clamp_unit(longint p);
      if (p < 0) return 0;
      if (p > PH_ONE) return PH_ONE;
      return p;
    endfunction

    function void clear_run();
      canceled = 1'b0; started = 1'b0; ended = 1'b0;
      flipped = 1'b0; runs = '0;
    endfunction

    // Phase, fill rules and expiry for one frame.
    function void advance_frame(bit [31:0] stamp, inout seq_word_t w);
      longint    ph;
      longint    mag;
      longint    q;
      bit        early;
      bit        after;
      bit        expired;
      bit        neg;
      bit        more;
      bit [31:0] base;
      bit [31:0] diff;
      int        rc;
      rc = rep_count;
      early = 1'b0;
      after = 1'b0;
      if (start_pending) begin
        start_ms = stamp;
        start_pending = 1'b0;
      end
      if (canceled) begin
        // a canceled run sits past its end, saturated
        ph = PH_MAX;
        after = 1'b1;
        expired = 1'b1;
      end else if (dur_ms != 0) begin
        base = start_ms + ((runs == 0) ? {16'd0, offset_ms} : 32'd0);
        diff = stamp - base;
        neg  = diff[31];
        mag  = neg ? (64'h1_0000_0000 - diff) : diff;
        if (mag >= longint'(dur_ms) * 4) begin
          ph = neg ? PH_MIN : PH_MAX;
        end else begin
          q  = (mag << FRAC) / longint'(dur_ms);
          ph = clip_phase(neg ? -q : q);
        end
        early   = neg;
        after   = !neg && (mag > longint'(dur_ms));
        expired = !neg && (mag >= longint'(dur_ms));
      end else begin
        // zero duration: a step at the start time, offset ignored
        diff    = stamp - start_ms;
        ph      = diff[31] ? 0 : PH_ONE;
        expired = !diff[31];
      end
      more = !expired;
      if (!fill_on || rc != 0) begin
        ph = clamp_unit(ph);
        early = 1'b0;
        after = 1'b0;
      end
      if ((!early || fill_bef) && (!after || fill_aft)) begin
        if (!started) begin
          started = 1'b1;
          w.start_event = 1'b1;
        end
        if (fill_on) ph = clamp_unit(ph);
        if (flipped) ph = clip_phase(PH_ONE - ph);
        w.applied = 1'b1;
        w.phase = ph[FRAC+1:0];
      end
      if (expired) begin
        if (rc == int'(runs) || canceled) begin
          if (!ended) begin
            ended = 1'b1;
            w.end_event = 1'b1;
          end
        end else begin
          // repeat_count of zero with runs already done reloads runs with one
          runs = (rc > 0) ? runs + 16'd1 : 16'd1;
          if (rev_mode) flipped = !flipped;
          start_ms = stamp;
          more = 1'b1;
          w.repeat_event = 1'b1;
        end
      end
      w.more = more;
    endfunction

    function void note_event(logic [OPC_W-1:0] op, logic [NOW_W-1:0] stamp);
      seq_word_t w;
      w = '0;
      case (op)
        OP_FRAME: advance_frame(stamp, w);
        OP_START_NEXT: begin
          start_pending = 1'b1;
          clear_run();
        end
        OP_START_AT: begin
          start_ms = stamp;
          start_pending = 1'b0;
          clear_run();
        end
        OP_CANCEL: begin
          if (started && !ended) begin
            canceled = 1'b1;
            ended = 1'b1;
            w.end_event = 1'b1;
          end
        end
        OP_PAUSE: begin
          if (!ended && !paused) begin
            paused = 1'b1;
            pause_ms = stamp;
          end
        end
        OP_RESUME: begin
          if (!ended && paused) begin
            paused = 1'b0;
            if (!start_pending) start_ms = start_ms + (stamp - pause_ms);
          end
        end
        default: ;
      endcase
      w.is_started = started;
      w.is_ended = ended;
      expected_words.push_back(w);
    endfunction

    function string describe(seq_word_t w);
      return $sformatf({"applied=%0b phase=%0d more=%0b start=%0b repeat=%0b end=%0b ",
                        "started=%0b ended=%0b pad=%h"},
                       w.applied, $signed(w.phase), w.more, w.start_event,
                       w.repeat_event, w.end_event, w.is_started, w.is_ended, w.pad);
    endfunction

    function void check_word(seq_word_t got);
      seq_word_t exp;
      bit        bad;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("output word %0d with none expected: %s", words_checked, describe(got));
        return;
      end
      exp = expected_words.pop_front();
      bad = (got.applied !== exp.applied) || (got.phase !== exp.phase) ||
            (got.more !== exp.more) || (got.start_event !== exp.start_event) ||
            (got.repeat_event !== exp.repeat_event) || (got.end_event !== exp.end_event) ||
            (got.is_started !== exp.is_started) || (got.is_ended !== exp.is_ended) ||
            (got.pad !== exp.pad);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("output word %0d mismatch at %0t", words_checked, $realtime);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [NOW_W-1:0]    s_tdata;    // [31:0] now_ms
  logic [OPC_W-1:0]    s_tuser;    // [2:0] opcode
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;    // see seq_word_t
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  bit                  idle_on = 1'b0;
  int                  stall_left = 0;
  int                  quiet_cycles = 0;
  int                  real_items = 0;
  timeline_scoreboard  sb = new();

  animation_timeline_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drop ready in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every word the receiver takes; values sampled here are pre-edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(seq_word_t'(m_tdata));
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one word, optionally after a gap, and hold it until it is taken.
  // Valid stays high on return so that back-to-back words need no toggle.
  task automatic push_event(logic [OPC_W-1:0] op, logic [NOW_W-1:0] stamp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= stamp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(op, stamp);
    if (op != OP_RSVD_LO && op != OP_RSVD_HI) real_items++;
  endtask

  // Drop valid, wait for every predicted word, then let the block go idle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Hold one register write for a cycle; the caller drops the enable.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  // Reprogram every register, only with the block drained.
  task automatic program_timing(logic [15:0] dur, logic [15:0] off, logic [16:0] rc,
                                bit rev, bit fb, bit fa, bit fen);
    wait_drained();
    write_reg(REG_DURATION, {1'b0, dur});
    write_reg(REG_OFFSET, {1'b0, off});
    write_reg(REG_REPEAT, rc);
    write_reg(REG_REVERSE, {16'd0, rev});
    write_reg(REG_FILL_BEF, {16'd0, fb});
    write_reg(REG_FILL_AFT, {16'd0, fa});
    write_reg(REG_FILL_EN, {16'd0, fen});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          target;
    int          span;
    int          jump;
    int          pick;
    bit [31:0]   t;
    logic [15:0] dur;
    logic [15:0] off;
    logic [16:0] rc;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_FRAME;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_DURATION;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero duration, so the first frame is a step that both
    // starts and ends the animation. Ignored opcodes and dead events follow.
    push_event(OP_FRAME, 32'h0000_0000);
    push_event(OP_RSVD_LO, 32'hFFFF_FFFF);
    push_event(OP_RSVD_HI, 32'h0000_0000);
    push_event(OP_CANCEL, 32'd5);
    push_event(OP_PAUSE, 32'd10);
    push_event(OP_RESUME, 32'd20);
    // step seen before the start time, then on it
    push_event(OP_START_AT, 32'd50);
    push_event(OP_FRAME, 32'd40);
    push_event(OP_FRAME, 32'd50);

    // Widest timing, repeat forever with reverse, fill off so the phase is clamped.
    program_timing(16'hFFFF, 16'hFFFF, '1, 1'b1, 1'b1, 1'b1, 1'b0);
    push_event(OP_START_AT, 32'hFFFF_FFFF);
    push_event(OP_FRAME, 32'h0000_0000);
    push_event(OP_PAUSE, 32'h0000_0100);
    push_event(OP_FRAME, 32'h0001_0000);
    push_event(OP_RESUME, 32'h0002_0000);
    push_event(OP_FRAME, 32'h8000_0000);
    push_event(OP_FRAME, 32'h8000_8000);
    push_event(OP_CANCEL, 32'h8000_9000);
    push_event(OP_FRAME, 32'h8000_A000);
    push_event(OP_START_NEXT, 32'h0000_0000);
    push_event(OP_FRAME, 32'h7FFF_FFFF);

    // One repeat in reverse, then drop repeat_count to zero with a run done.
    program_timing(16'd100, 16'd0, 17'd1, 1'b1, 1'b1, 1'b1, 1'b1);
    push_event(OP_START_AT, 32'd1000);
    push_event(OP_FRAME, 32'd1000);
    push_event(OP_FRAME, 32'd1100);
    push_event(OP_FRAME, 32'd1150);
    program_timing(16'd100, 16'd0, 17'd0, 1'b0, 1'b1, 1'b0, 1'b1);
    push_event(OP_FRAME, 32'd700);
    push_event(OP_FRAME, 32'd1200);

    // Random phases: fresh timing, a start, then a timeline of mostly frames
    // on an advancing clock, mixed with pauses, cancels, restarts and noise.
    target = real_items + RANDOM_ITEMS;
    while (real_items < target) begin
      case ($urandom_range(0, 9))
        0:       dur = 16'd0;
        1:       dur = 16'hFFFF;
        2:       dur = 16'd1;
        default: dur = 16'($urandom_range(2, 300));
      endcase
      case ($urandom_range(0, 7))
        0:       off = 16'hFFFF;
        1, 2:    off = 16'($urandom_range(0, dur));
        default: off = 16'd0;
      endcase
      case ($urandom_range(0, 7))
        0:       rc = '1;
        1:       rc = 17'd65535;
        2, 3:    rc = 17'd0;
        default: rc = 17'($urandom_range(1, 3));
      endcase
      program_timing(dur, off, rc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      idle_on = (real_items < target - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      span = dur / 4 + 2;
      jump = 2 * dur + off + 4;
      // now and then start just below the wrap of the millisecond counter
      if ($urandom_range(0, 3) == 0)
        t = 32'hFFFF_FFFF - $urandom_range(0, 4 * dur + 8);
      else
        t = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_event(OP_START_NEXT, t);
        4, 5, 6, 7: push_event(OP_START_AT, t + $urandom_range(0, dur / 2));
        default: ;
      endcase
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          push_event(OP_FRAME, t);
          t += $urandom_range(0, span);
        end else if (pick < 72) begin
          push_event(OP_FRAME, t - $urandom_range(0, jump));
        end else if (pick < 75) begin
          t += $urandom_range(0, jump);
          push_event(OP_FRAME, t);
        end else if (pick < 81) begin
          push_event(OP_PAUSE, t);
        end else if (pick < 87) begin
          t += $urandom_range(0, span);
          push_event(OP_RESUME, t);
        end else if (pick < 90) begin
          push_event(OP_CANCEL, t);
        end else if (pick < 92) begin
          push_event(OP_START_NEXT, t);
        end else if (pick < 94) begin
          push_event(OP_START_AT, t + $urandom_range(0, span));
        end else begin
          push_event(OPC_W'($urandom_range(OP_FRAME, OP_RSVD_HI)), $urandom());
        end
      end
    end

    idle_on = 1'b0;
    wait_drained();
    if (sb.mismatches == 0 && sb.expected_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ats_pkg.sv
hdl/animation_timeline_sequencer_top.sv
dv/tb_animation_timeline_sequencer_top.sv
